@@ rtl/toroidal_shadow_cache_scroller_defines.svh @@
// Assertion macros shared by the RTL files of the scroller.
`ifndef TOROIDAL_SHADOW_CACHE_SCROLLER_DEFINES_SVH
`define TOROIDAL_SHADOW_CACHE_SCROLLER_DEFINES_SVH

`ifndef ASSERT_OFF

// Concurrent assertion on an explicit clock and active-low reset.
`define TSCS_ASSERT_CR(lbl, prop, clk, rstn) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed: %m");

// Concurrent assertion on the block clock and reset.
`define TSCS_ASSERT(lbl, prop) `TSCS_ASSERT_CR(lbl, prop, clk_i, rst_ni)

`else

`define TSCS_ASSERT_CR(lbl, prop, clk, rstn)

`define TSCS_ASSERT(lbl, prop)

`endif

`endif

@@ rtl/tscs_pkg.sv @@
package tscs_pkg;

  // Number of cascades held by the cache state.
  localparam int CASCADES = 4;
  localparam int CASC_W   = $clog2(CASCADES);
  localparam int CNT_W    = $clog2(CASCADES + 1);

  // Field widths.
  localparam int MAP_W   = 13;
  localparam int RING_W  = 12;
  localparam int COORD_W = 32;
  localparam int CFG_W   = 13;
  localparam int IDX_W   = 3;

  // Map size limits.
  localparam logic [MAP_W-1:0] MAP_DEFAULT = 13'd1024;
  localparam logic [MAP_W-1:0] MAP_MAX     = 13'd4096;

  // Operand of the modulo unit: ring offset plus or minus one band step.
  localparam int MOD_VAL_W = 15;
  localparam int MOD_MAG_W = MOD_VAL_W - 1;
  localparam int MOD_CNT_W = $clog2(MOD_MAG_W + 1);

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_MAP_SIZE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_CASCADE_COUNT = 3'd1;
  localparam logic [IDX_W-1:0] REG_BAND_C1       = 3'd2;
  localparam logic [IDX_W-1:0] REG_BAND_C2       = 3'd3;
  localparam logic [IDX_W-1:0] REG_BAND_C3       = 3'd4;
  localparam logic [IDX_W-1:0] REG_ANCHOR_EN     = 3'd5;

  // Item modes.
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_INVAL  = 1'b1;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_HIT    = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_FULL   = 2'd2
  } kind_e;

  // One result beat.
  typedef struct packed {
    logic [1:0]        cascade_out;
    kind_e             kind;
    logic              rect_valid;
    logic [RING_W-1:0] rect_x;
    logic [RING_W-1:0] rect_y;
    logic [MAP_W-1:0]  rect_w;
    logic [MAP_W-1:0]  rect_h;
    logic [RING_W-1:0] ring_x;
    logic [RING_W-1:0] ring_y;
    logic              last;
  } res_t;

  // Request to the modulo unit.
  typedef struct packed {
    logic                 start;
    logic [MOD_VAL_W-1:0] value;
    logic [MAP_W-1:0]     modulus;
  } mod_req_t;

  // Response of the modulo unit.
  typedef struct packed {
    logic              done;
    logic [RING_W-1:0] result;
  } mod_rsp_t;

endpackage

@@ rtl/toroidal_shadow_cache_scroller.sv @@
// Rolling shadow-map cache manager for up to four cascades.
// Input channel (valid/stall): one beat is an update for one cascade (origin and
// depth anchor) or an invalidate that clears the valid bits of cascades 1 and up.
// Output channel (valid/stall): one to four result beats per update, the final one
// marked by last_o; invalidates and cascades not in use give no beat.
// Configuration: write enable, register index and data; the user must write it only
// while idle, which the block itself does not enforce.
// Sequence: a hit or a full redraw passes S_DIFF and S_CLASS and then loads its beat
// into the output register. A strip scroll runs four modulo passes on the shared
// bit-serial modulo unit before its first beat, and the strips follow one after
// another. The block takes no new item until the current one is done.
// Reset: all cascades invalid, ring offsets zero, map size 1024, four cascades,
// bands zero, anchor check off. No clearing pass is needed.
// Stall: a beat waits in the output register; the sequencer holds on the next beat
// and in_stall_o stays high until the item's last beat has been loaded.
`include "toroidal_shadow_cache_scroller_defines.svh"

module toroidal_shadow_cache_scroller import tscs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port.
  input  logic               cfg_we_i,
  input  logic [IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [1:0]         cascade_i,
  input  logic [COORD_W-1:0] origin_x_i,
  input  logic [COORD_W-1:0] origin_y_i,
  input  logic [COORD_W-1:0] depth_anchor_i,
  // Output channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         cascade_out_o,
  output logic [1:0]         kind_o,
  output logic               rect_valid_o,
  output logic [RING_W-1:0]  rect_x_o,
  output logic [RING_W-1:0]  rect_y_o,
  output logic [MAP_W-1:0]   rect_w_o,
  output logic [MAP_W-1:0]   rect_h_o,
  output logic [RING_W-1:0]  ring_x_o,
  output logic [RING_W-1:0]  ring_y_o,
  output logic               last_o
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'h0001,
    S_DIFF  = 14'h0002,
    S_CLASS = 14'h0004,
    S_MX    = 14'h0008,
    S_MY    = 14'h0010,
    S_SX    = 14'h0020,
    S_SY    = 14'h0040,
    S_EX1   = 14'h0080,
    S_EX2   = 14'h0100,
    S_EY1   = 14'h0200,
    S_EY2   = 14'h0400,
    S_ENONE = 14'h0800,
    S_EHIT  = 14'h1000,
    S_EFULL = 14'h2000
  } state_e;

  // Configuration registers.
  logic [MAP_W-1:0] map_size_q;
  logic [2:0]       cascade_count_q;
  logic [MAP_W-1:0] band_q [3];
  logic             anchor_en_q;

  // Per-cascade state.
  logic [CASCADES-1:0] valid_q;
  logic [COORD_W-1:0]  saved_x_q  [CASCADES];
  logic [COORD_W-1:0]  saved_y_q  [CASCADES];
  logic [COORD_W-1:0]  saved_an_q [CASCADES];
  logic [RING_W-1:0]   ring_x_q   [CASCADES];
  logic [RING_W-1:0]   ring_y_q   [CASCADES];

  // Item registers.
  state_e             state_q, state_d;
  logic [1:0]         cascade_q;
  logic [COORD_W-1:0] ox_q, oy_q, an_q;
  logic [COORD_W:0]   sx_q, sy_q;
  logic               amis_q;
  logic [RING_W-1:0]  nx_q, ny_q, stx_q, sty_q;

  // Output register.
  logic out_valid_q;
  res_t out_q;

  logic [CASC_W-1:0]  idx;
  logic [MAP_W-1:0]   m_eff;
  logic [CNT_W-1:0]   count_eff;
  logic               in_range;
  logic               in_fire;
  logic [MAP_W-1:0]   band;
  logic [COORD_W:0]   band_w;
  logic               sxz, syz, hit, x_ok, y_ok, scroll, go_full;
  logic               sx_pos, sy_pos;
  logic               have_x, have_y, split_x, split_y;
  logic [MAP_W-1:0]   rest_x, rest_y, first_x, first_y, sec_x, sec_y;
  logic               out_free, emit, last_d;
  res_t               beat;
  mod_req_t           mod_req;
  mod_rsp_t           mod_rsp;
  logic               class_full, class_scroll, ring_wr;

  assign idx = CASC_W'(cascade_q);

  // Effective map size and cascade count.
  always_comb begin
    if (map_size_q == '0) begin
      m_eff = MAP_DEFAULT;
    end else if (map_size_q > MAP_MAX) begin
      m_eff = MAP_MAX;
    end else begin
      m_eff = map_size_q;
    end
    if ((cascade_count_q == '0) || (int'(cascade_count_q) > CASCADES)) begin
      count_eff = CNT_W'(CASCADES);
    end else begin
      count_eff = CNT_W'(cascade_count_q);
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_range   = (CNT_W'(cascade_i) < count_eff);

  // Band of the current cascade; cascade zero has none.
  always_comb begin
    case (cascade_q)
      2'd1:    band = band_q[0];
      2'd2:    band = band_q[1];
      2'd3:    band = band_q[2];
      default: band = '0;
    endcase
  end

  // Classification of the shift.
  assign band_w  = {{(COORD_W + 1 - MAP_W){1'b0}}, band};
  assign sxz     = (sx_q == '0);
  assign syz     = (sy_q == '0);
  assign hit     = sxz && syz;
  assign x_ok    = sxz || (sx_q == band_w) || (sx_q == ((COORD_W + 1)'(0) - band_w));
  assign y_ok    = syz || (sy_q == band_w) || (sy_q == ((COORD_W + 1)'(0) - band_w));
  assign scroll  = (band != '0) && x_ok && y_ok;
  assign go_full = (cascade_q == 2'd0) || !valid_q[idx] || amis_q || (!hit && !scroll);
  assign sx_pos  = !sx_q[COORD_W] && !sxz;
  assign sy_pos  = !sy_q[COORD_W] && !syz;

  // Strip plan: a strip as wide as the map or wider is dropped; one crossing the seam splits.
  assign have_x  = !sxz && (band < m_eff);
  assign have_y  = !syz && (band < m_eff);
  assign rest_x  = m_eff - {1'b0, stx_q};
  assign rest_y  = m_eff - {1'b0, sty_q};
  assign split_x = (band > rest_x);
  assign split_y = (band > rest_y);
  assign first_x = split_x ? rest_x : band;
  assign first_y = split_y ? rest_y : band;
  assign sec_x   = band - rest_x;
  assign sec_y   = band - rest_y;

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer, modulo requests and beat assembly.
  always_comb begin
    state_d          = state_q;
    mod_req.start    = 1'b0;
    mod_req.value    = '0;
    mod_req.modulus  = m_eff;
    emit             = 1'b0;
    beat             = '0;
    beat.cascade_out = cascade_q;
    beat.kind        = KIND_SCROLL;
    beat.ring_x      = nx_q;
    beat.ring_y      = ny_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (mode_i == MODE_UPDATE) && in_range) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        state_d = S_CLASS;
      end
      S_CLASS: begin
        if (go_full) begin
          state_d = S_EFULL;
        end else if (hit) begin
          state_d = S_EHIT;
        end else begin
          state_d       = S_MX;
          mod_req.start = 1'b1;
          mod_req.value = {{(MOD_VAL_W - RING_W){1'b0}}, ring_x_q[idx]} +
                          sx_q[MOD_VAL_W-1:0];
        end
      end
      S_MX: begin
        if (mod_rsp.done) begin
          state_d       = S_MY;
          mod_req.start = 1'b1;
          mod_req.value = {{(MOD_VAL_W - RING_W){1'b0}}, ring_y_q[idx]} +
                          sy_q[MOD_VAL_W-1:0];
        end
      end
      S_MY: begin
        if (mod_rsp.done) begin
          state_d       = S_SX;
          mod_req.start = 1'b1;
          mod_req.value = {{(MOD_VAL_W - RING_W){1'b0}}, nx_q} -
                          (sx_pos ? sx_q[MOD_VAL_W-1:0] : MOD_VAL_W'(0));
        end
      end
      S_SX: begin
        if (mod_rsp.done) begin
          state_d       = S_SY;
          mod_req.start = 1'b1;
          mod_req.value = {{(MOD_VAL_W - RING_W){1'b0}}, ny_q} -
                          (sy_pos ? sy_q[MOD_VAL_W-1:0] : MOD_VAL_W'(0));
        end
      end
      S_SY: begin
        if (mod_rsp.done) begin
          state_d = have_x ? S_EX1 : (have_y ? S_EY1 : S_ENONE);
        end
      end
      S_EX1: begin
        emit            = 1'b1;
        beat.rect_valid = 1'b1;
        beat.rect_x     = stx_q;
        beat.rect_w     = first_x;
        beat.rect_h     = m_eff;
        if (out_free) begin
          state_d = split_x ? S_EX2 : (have_y ? S_EY1 : S_IDLE);
        end
      end
      S_EX2: begin
        emit            = 1'b1;
        beat.rect_valid = 1'b1;
        beat.rect_w     = sec_x;
        beat.rect_h     = m_eff;
        if (out_free) begin
          state_d = have_y ? S_EY1 : S_IDLE;
        end
      end
      S_EY1: begin
        emit            = 1'b1;
        beat.rect_valid = 1'b1;
        beat.rect_y     = sty_q;
        beat.rect_w     = m_eff;
        beat.rect_h     = first_y;
        if (out_free) begin
          state_d = split_y ? S_EY2 : S_IDLE;
        end
      end
      S_EY2: begin
        emit            = 1'b1;
        beat.rect_valid = 1'b1;
        beat.rect_w     = m_eff;
        beat.rect_h     = sec_y;
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_ENONE: begin
        emit = 1'b1;
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_EHIT: begin
        emit        = 1'b1;
        beat.kind   = KIND_HIT;
        beat.ring_x = ring_x_q[idx];
        beat.ring_y = ring_y_q[idx];
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_EFULL: begin
        emit            = 1'b1;
        beat.kind       = KIND_FULL;
        beat.rect_valid = 1'b1;
        beat.rect_w     = m_eff;
        beat.rect_h     = m_eff;
        beat.ring_x     = '0;
        beat.ring_y     = '0;
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    last_d    = emit && (state_d == S_IDLE);
    beat.last = last_d;
  end

  assign class_full   = (state_q == S_CLASS) && go_full;
  assign class_scroll = (state_q == S_CLASS) && !go_full && !hit;
  assign ring_wr      = (state_q == S_SY) && mod_rsp.done;

  // Shared modulo unit.
  tscs_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // Control state, configuration, valid bits and ring offsets.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      out_valid_q     <= 1'b0;
      map_size_q      <= MAP_DEFAULT;
      cascade_count_q <= 3'd4;
      band_q[0]       <= '0;
      band_q[1]       <= '0;
      band_q[2]       <= '0;
      anchor_en_q     <= 1'b0;
      valid_q         <= '0;
      for (int i = 0; i < CASCADES; i++) begin
        ring_x_q[i] <= '0;
        ring_y_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (emit && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MAP_SIZE:      map_size_q      <= cfg_data_i;
          REG_CASCADE_COUNT: cascade_count_q <= cfg_data_i[2:0];
          REG_BAND_C1:       band_q[0]       <= cfg_data_i;
          REG_BAND_C2:       band_q[1]       <= cfg_data_i;
          REG_BAND_C3:       band_q[2]       <= cfg_data_i;
          REG_ANCHOR_EN:     anchor_en_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_fire && (mode_i == MODE_INVAL)) begin
        valid_q <= valid_q & CASCADES'(1);
      end
      if (class_full) begin
        valid_q[idx]  <= 1'b1;
        ring_x_q[idx] <= '0;
        ring_y_q[idx] <= '0;
      end
      if (ring_wr) begin
        ring_x_q[idx] <= nx_q;
        ring_y_q[idx] <= ny_q;
      end
    end
  end

  // Item payload, saved origins and the output beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cascade_q <= cascade_i;
      ox_q      <= origin_x_i;
      oy_q      <= origin_y_i;
      an_q      <= depth_anchor_i;
    end
    if (state_q == S_DIFF) begin
      sx_q   <= {ox_q[COORD_W-1], ox_q} - {saved_x_q[idx][COORD_W-1], saved_x_q[idx]};
      sy_q   <= {oy_q[COORD_W-1], oy_q} - {saved_y_q[idx][COORD_W-1], saved_y_q[idx]};
      amis_q <= anchor_en_q && (saved_an_q[idx] != an_q);
    end
    if (class_full || class_scroll) begin
      saved_x_q[idx]  <= ox_q;
      saved_y_q[idx]  <= oy_q;
      saved_an_q[idx] <= an_q;
    end
    if (mod_rsp.done) begin
      if (state_q == S_MX) begin
        nx_q <= mod_rsp.result;
      end
      if (state_q == S_MY) begin
        ny_q <= mod_rsp.result;
      end
      if (state_q == S_SX) begin
        stx_q <= mod_rsp.result;
      end
      if (state_q == S_SY) begin
        sty_q <= mod_rsp.result;
      end
    end
    if (emit && out_free) begin
      out_q <= beat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cascade_out_o = out_q.cascade_out;
  assign kind_o        = out_q.kind;
  assign rect_valid_o  = out_q.rect_valid;
  assign rect_x_o      = out_q.rect_x;
  assign rect_y_o      = out_q.rect_y;
  assign rect_w_o      = out_q.rect_w;
  assign rect_h_o      = out_q.rect_h;
  assign ring_x_o      = out_q.ring_x;
  assign ring_y_o      = out_q.ring_y;
  assign last_o        = out_q.last;

  `TSCS_ASSERT(a_last_ends_item, emit && out_free && last_d |=> state_q == S_IDLE)
  `TSCS_ASSERT(a_mod_done_in_pass, mod_rsp.done |-> (state_q == S_MX) || (state_q == S_MY) || (state_q == S_SX) || (state_q == S_SY))
  `TSCS_ASSERT(a_rect_nonempty, out_valid_o && rect_valid_o |-> (rect_w_o != '0) && (rect_h_o != '0))

endmodule

@@ rtl/tscs_mod.sv @@
`include "toroidal_shadow_cache_scroller_defines.svh"

// Bit-serial floored modulo: result = value mod modulus, always in [0, modulus).
module tscs_mod import tscs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 fix_q;
  logic                 done_q;
  logic [MOD_CNT_W-1:0] cnt_q;
  logic                 neg_q;
  logic [MOD_MAG_W-1:0] mag_q;
  logic [RING_W-1:0]    rem_q;
  logic [MAP_W-1:0]     mod_q;
  logic [RING_W-1:0]    result_q;

  logic [MOD_MAG_W-1:0] mag_in;
  logic [MAP_W-1:0]     trial;
  logic [RING_W-1:0]    rem_step;
  logic [RING_W-1:0]    rem_fixed;

  // Magnitude of the signed operand.
  assign mag_in = req_i.value[MOD_VAL_W-1] ? MOD_MAG_W'(-req_i.value)
                                           : req_i.value[MOD_MAG_W-1:0];

  // One restoring step: shift in the next bit and subtract when it fits.
  assign trial    = {rem_q, mag_q[MOD_MAG_W-1]};
  assign rem_step = (trial >= mod_q) ? RING_W'(trial - mod_q) : trial[RING_W-1:0];

  // A negative operand with a nonzero remainder folds back into range.
  assign rem_fixed = (neg_q && (rem_q != '0)) ? RING_W'(mod_q - {1'b0, rem_q}) : rem_q;

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        fix_q  <= 1'b0;
        cnt_q  <= MOD_CNT_W'(MOD_MAG_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == MOD_CNT_W'(1)) begin
          busy_q <= 1'b0;
          fix_q  <= 1'b1;
        end
      end else if (fix_q) begin
        fix_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.value[MOD_VAL_W-1];
      mag_q <= mag_in;
      rem_q <= '0;
      mod_q <= req_i.modulus;
    end else if (busy_q) begin
      rem_q <= rem_step;
      mag_q <= {mag_q[MOD_MAG_W-2:0], 1'b0};
    end else if (fix_q) begin
      result_q <= rem_fixed;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = result_q;

  `TSCS_ASSERT(a_no_start_busy, req_i.start |-> !busy_q && !fix_q)
  `TSCS_ASSERT(a_rem_in_range, busy_q |-> ({1'b0, rem_q} < mod_q))
  `TSCS_ASSERT(a_result_in_range, done_q |-> ({1'b0, result_q} < mod_q))

endmodule
